/* src/rcwd_pkg.sv */
// Shared types and constants for the RC channel watchdog and failsafe vote.
// No dependencies; used by every module of the block.
`default_nettype none

package rcwd_pkg;

   // Field and state widths
   localparam int CHAN_W     = 8;    // channel number on the request
   localparam int ELAPSED_W  = 8;    // elapsed milliseconds on a tick
   localparam int MS_W       = 10;   // timeout and vote period registers
   localparam int MASK_W     = 8;    // required mask and visible valid mask
   localparam int TIMER_W    = 11;   // channel and vote timers
   localparam int VOTE_W     = 3;    // signed link-loss vote
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Defaults
   localparam int                NUM_CHANNELS_DEF  = 8;
   localparam logic [MS_W-1:0]   TIMEOUT_RESET     = 10'd500;
   localparam logic [MS_W-1:0]   VOTE_PERIOD_RESET = 10'd500;
   localparam logic [MASK_W-1:0] REQ_MASK_RESET    = 8'h0F;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOTE_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_MASK   = 2'd2;

   // Command codes
   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // One accepted request item
   typedef struct packed {
      logic                 command;
      logic [CHAN_W-1:0]    channel;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic                 receiver_failsafe;
      logic                 armed;
      logic                 gps_enabled;
      logic                 in_takeoff;
   } item_type;

   // Single-item request pulses raised by the vote
   typedef struct packed {
      logic land;
      logic home;
      logic finish;
   } request_type;

endpackage

`default_nettype wire

/* src/rcwd_chan_timers.sv */
// Per-channel timers and valid bits: feed clears one timer, tick ages all.
// Depends on rcwd_pkg.
`default_nettype none

module rcwd_chan_timers #(
   parameter int NUM_CHANNELS = rcwd_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           command,
   input  wire logic [rcwd_pkg::CHAN_W-1:0]    channel,
   input  wire logic [rcwd_pkg::ELAPSED_W-1:0] elapsed_ms,
   input  wire logic [rcwd_pkg::MS_W-1:0]      channel_timeout_ms,
   output logic      [rcwd_pkg::MASK_W-1:0]    valid_view_in
);

   localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [rcwd_pkg::CHAN_W-1:0] LAST_CH =
      rcwd_pkg::CHAN_W'(NUM_CHANNELS - 1);

   logic [rcwd_pkg::TIMER_W-1:0] timer_ff [NUM_CHANNELS];
   logic [rcwd_pkg::TIMER_W-1:0] timer_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]      valid_ff;
   logic [NUM_CHANNELS-1:0]      valid_in;
   logic [SEL_W-1:0]             sel;

   // Clamp the fed channel to the last one
   always_comb begin
      if (channel > LAST_CH) begin
         sel = SEL_W'(NUM_CHANNELS - 1);
      end else begin
         sel = channel[SEL_W-1:0];
      end
   end

   // Next timers and valid bits
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         timer_in[i] = timer_ff[i];
         valid_in[i] = valid_ff[i];
         if (command == rcwd_pkg::CMD_FEED) begin
            if (sel == SEL_W'(i)) begin
               timer_in[i] = '0;
            end
         end else if (timer_ff[i] < rcwd_pkg::TIMER_W'(channel_timeout_ms)) begin
            // below the 10-bit bound plus 8 bits: never wraps in 11 bits
            timer_in[i] = timer_ff[i] + rcwd_pkg::TIMER_W'(elapsed_ms);
            valid_in[i] = 1'b1;
         end else begin
            valid_in[i] = 1'b0;
         end
      end
   end

   // Visible view: channels 0 to 7, absent channels read invalid
   always_comb begin
      valid_view_in = '0;
      for (int i = 0; i < rcwd_pkg::MASK_W; i++) begin
         if (i < NUM_CHANNELS) begin
            valid_view_in[i] = valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            timer_ff[i] <= '0;
         end
      end else if (advance) begin
         valid_ff <= valid_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            timer_ff[i] <= timer_in[i];
         end
      end
   end

endmodule

`default_nettype wire

/* src/rcwd_vote.sv */
// Link-loss vote: vote timer, signed vote counter, link-lost flag, request pulses.
// Depends on rcwd_pkg.
`default_nettype none

module rcwd_vote (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire rcwd_pkg::item_type             item,
   input  wire logic [rcwd_pkg::MS_W-1:0]      vote_period_ms,
   input  wire logic [rcwd_pkg::MASK_W-1:0]    required_mask,
   input  wire logic [rcwd_pkg::MASK_W-1:0]    valid_view,
   output logic                                link_lost_in,
   output rcwd_pkg::request_type               requests
);

   logic [rcwd_pkg::TIMER_W-1:0]       vote_timer_ff, vote_timer_in;
   logic [rcwd_pkg::TIMER_W-1:0]       timer_sum;
   logic signed [rcwd_pkg::VOTE_W-1:0] loss_vote_ff, loss_vote_in, vote_sum;
   logic                               link_lost_ff;
   logic                               vote_up;

   always_comb begin
      timer_sum = vote_timer_ff + rcwd_pkg::TIMER_W'(item.elapsed_ms);
      vote_up   = ((valid_view & required_mask) != required_mask) ||
                  item.receiver_failsafe;
      vote_sum  = vote_up ? loss_vote_ff + 3'sd1 : loss_vote_ff - 3'sd1;
   end

   // Vote update on a tick once the period has run out
   always_comb begin
      vote_timer_in = vote_timer_ff;
      loss_vote_in  = loss_vote_ff;
      link_lost_in  = link_lost_ff;
      requests      = '0;
      if (item.command == rcwd_pkg::CMD_TICK) begin
         vote_timer_in = timer_sum;
         if (timer_sum >= rcwd_pkg::TIMER_W'(vote_period_ms)) begin
            vote_timer_in = '0;
            loss_vote_in  = vote_sum;
            if (vote_sum >= 3'sd2) begin
               loss_vote_in  = '0;
               link_lost_in  = 1'b1;
               requests.home = item.armed && item.gps_enabled;
               requests.land = item.armed && !item.gps_enabled;
            end else if (vote_sum <= -3'sd2) begin
               loss_vote_in = '0;
               if (link_lost_ff) begin
                  link_lost_in    = 1'b0;
                  requests.finish = item.in_takeoff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_timer_ff <= '0;
         loss_vote_ff  <= '0;
         link_lost_ff  <= 1'b0;
      end else if (advance) begin
         vote_timer_ff <= vote_timer_in;
         loss_vote_ff  <= loss_vote_in;
         link_lost_ff  <= link_lost_in;
      end
   end

endmodule

`default_nettype wire

/* src/rc_channel_watchdog_failsafe_core.sv */
// Top level of the RC channel watchdog with link-loss failsafe vote.
// Depends on rcwd_pkg, rcwd_chan_timers and rcwd_vote.
//
// Each request item (a channel feed or a time tick) yields exactly one response
// item. The block takes one item per clock cycle unless the response side stalls:
// an item is captured in the input register, the channel timers and the vote
// are updated from it as it leaves that register, and the response lands in the
// output register, which drives rsp_valid. The input register keeps accepting
// while a response waits, stalling only when both stages are full.
// Configuration writes take effect at once and must be made while no item is
// in flight.
`default_nettype none

module rc_channel_watchdog_failsafe_core #(
   parameter int NUM_CHANNELS = rcwd_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [rcwd_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic [rcwd_pkg::ELAPSED_W-1:0]  req_elapsed_ms,
   input  wire logic                            req_receiver_failsafe,
   input  wire logic                            req_armed,
   input  wire logic                            req_gps_enabled,
   input  wire logic                            req_in_takeoff,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [rcwd_pkg::MASK_W-1:0]     rsp_valid_mask,
   output logic                                 rsp_link_lost,
   output logic                                 rsp_land_request,
   output logic                                 rsp_home_request,
   output logic                                 rsp_takeoff_finish_request,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [rcwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcwd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [rcwd_pkg::MS_W-1:0]   timeout_ff;
   logic [rcwd_pkg::MS_W-1:0]   period_ff;
   logic [rcwd_pkg::MASK_W-1:0] req_mask_ff;

   logic                  s1_valid_ff;
   rcwd_pkg::item_type    s1_item_ff;
   logic                  advance;

   logic [rcwd_pkg::MASK_W-1:0] valid_view_in;
   logic                        link_lost_in;
   rcwd_pkg::request_type       requests;

   logic                        rsp_valid_ff;
   logic [rcwd_pkg::MASK_W-1:0] rsp_mask_ff;
   logic                        rsp_lost_ff;
   rcwd_pkg::request_type       rsp_req_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= rcwd_pkg::TIMEOUT_RESET;
         period_ff   <= rcwd_pkg::VOTE_PERIOD_RESET;
         req_mask_ff <= rcwd_pkg::REQ_MASK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rcwd_pkg::CSR_CHANNEL_TIMEOUT: timeout_ff  <= csr_wdata;
            rcwd_pkg::CSR_VOTE_PERIOD:     period_ff   <= csr_wdata;
            rcwd_pkg::CSR_REQUIRED_MASK:   req_mask_ff <= csr_wdata[rcwd_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: stage 1 moves on when the output register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.command           <= req_command;
         s1_item_ff.channel           <= req_channel;
         s1_item_ff.elapsed_ms        <= req_elapsed_ms;
         s1_item_ff.receiver_failsafe <= req_receiver_failsafe;
         s1_item_ff.armed             <= req_armed;
         s1_item_ff.gps_enabled       <= req_gps_enabled;
         s1_item_ff.in_takeoff        <= req_in_takeoff;
      end
   end

   rcwd_chan_timers #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_timers (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .command            (s1_item_ff.command),
      .channel            (s1_item_ff.channel),
      .elapsed_ms         (s1_item_ff.elapsed_ms),
      .channel_timeout_ms (timeout_ff),
      .valid_view_in      (valid_view_in)
   );

   rcwd_vote u_vote (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (s1_item_ff),
      .vote_period_ms (period_ff),
      .required_mask  (req_mask_ff),
      .valid_view     (valid_view_in),
      .link_lost_in   (link_lost_in),
      .requests       (requests)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mask_ff <= valid_view_in;
         rsp_lost_ff <= link_lost_in;
         rsp_req_ff  <= requests;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_valid_mask             = rsp_mask_ff;
   assign rsp_link_lost              = rsp_lost_ff;
   assign rsp_land_request           = rsp_req_ff.land;
   assign rsp_home_request           = rsp_req_ff.home;
   assign rsp_takeoff_finish_request = rsp_req_ff.finish;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for rc_channel_watchdog_failsafe_core: directed and random items,
// checked against an in-bench model of the channel timers and the link-loss vote.
// Depends on rcwd_pkg and the core RTL only.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH = rcwd_pkg::NUM_CHANNELS_DEF;

   // Expected response item
   typedef struct packed {
      logic [rcwd_pkg::MASK_W-1:0] valid_mask;
      logic                        link_lost;
      logic                        land;
      logic                        home;
      logic                        finish;
   } watchdog_result_type;

   // DUT signals; the driven inputs are known from time zero
   logic                            clock                 = 1'b0;
   logic                            reset                 = 1'b1;
   logic                            req_valid             = 1'b0;
   logic                            req_ready;
   logic                            req_command           = rcwd_pkg::CMD_FEED;
   logic [rcwd_pkg::CHAN_W-1:0]     req_channel           = '0;
   logic [rcwd_pkg::ELAPSED_W-1:0]  req_elapsed_ms        = '0;
   logic                            req_receiver_failsafe = 1'b0;
   logic                            req_armed             = 1'b0;
   logic                            req_gps_enabled       = 1'b0;
   logic                            req_in_takeoff        = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready             = 1'b0;
   logic [rcwd_pkg::MASK_W-1:0]     rsp_valid_mask;
   logic                            rsp_link_lost;
   logic                            rsp_land_request;
   logic                            rsp_home_request;
   logic                            rsp_takeoff_finish_request;
   logic                            csr_we                = 1'b0;
   logic [rcwd_pkg::CSR_IDX_W-1:0]  csr_index             = rcwd_pkg::CSR_CHANNEL_TIMEOUT;
   logic [rcwd_pkg::CSR_DATA_W-1:0] csr_wdata             = '0;

   // Model state and register copies
   logic [rcwd_pkg::TIMER_W-1:0] chan_timer [NUM_CH];
   logic [rcwd_pkg::MASK_W-1:0]  chan_valid;
   logic [rcwd_pkg::TIMER_W-1:0] vote_timer;
   int                           vote_count;
   logic                         lost_flag;
   logic [rcwd_pkg::MS_W-1:0]    timeout_ms;
   logic [rcwd_pkg::MS_W-1:0]    period_ms;
   logic [rcwd_pkg::MASK_W-1:0]  needed_mask;

   watchdog_result_type pending_results [$];

   int error_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int settings_count = 0;
   int land_seen      = 0;
   int home_seen      = 0;
   int finish_seen    = 0;
   int lost_seen      = 0;
   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int stall_left     = 0;

   rc_channel_watchdog_failsafe_core u_dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_command                (req_command),
      .req_channel                (req_channel),
      .req_elapsed_ms             (req_elapsed_ms),
      .req_receiver_failsafe      (req_receiver_failsafe),
      .req_armed                  (req_armed),
      .req_gps_enabled            (req_gps_enabled),
      .req_in_takeoff             (req_in_takeoff),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_valid_mask             (rsp_valid_mask),
      .rsp_link_lost              (rsp_link_lost),
      .rsp_land_request           (rsp_land_request),
      .rsp_home_request           (rsp_home_request),
      .rsp_takeoff_finish_request (rsp_takeoff_finish_request),
      .csr_we                     (csr_we),
      .csr_index                  (csr_index),
      .csr_wdata                  (csr_wdata)
   );

   // 8 ns clock
   always #4 clock = ~clock;

   // Model: state and registers at reset
   function automatic void clear_watchdog();
      for (int i = 0; i < NUM_CH; i++) chan_timer[i] = '0;
      chan_valid  = '0;
      vote_timer  = '0;
      vote_count  = 0;
      lost_flag   = 1'b0;
      timeout_ms  = rcwd_pkg::TIMEOUT_RESET;
      period_ms   = rcwd_pkg::VOTE_PERIOD_RESET;
      needed_mask = rcwd_pkg::REQ_MASK_RESET;
   endfunction

   // Model: apply one item, return the response it causes
   function automatic watchdog_result_type advance_watchdog(rcwd_pkg::item_type it);
      watchdog_result_type res;
      int unsigned         ch;
      res = '0;
      if (it.command == rcwd_pkg::CMD_FEED) begin
         if (it.channel > rcwd_pkg::CHAN_W'(NUM_CH - 1)) ch = NUM_CH - 1;
         else ch = 32'(it.channel);
         chan_timer[ch] = '0;
      end else begin
         // channel timers first, then the vote timer
         for (int i = 0; i < NUM_CH; i++) begin
            if (chan_timer[i] < rcwd_pkg::TIMER_W'(timeout_ms)) begin
               chan_timer[i] = chan_timer[i] + rcwd_pkg::TIMER_W'(it.elapsed_ms);
               chan_valid[i] = 1'b1;
            end else begin
               chan_valid[i] = 1'b0;
            end
         end
         vote_timer = vote_timer + rcwd_pkg::TIMER_W'(it.elapsed_ms);
         if (vote_timer >= rcwd_pkg::TIMER_W'(period_ms)) begin
            vote_timer = '0;
            if ((chan_valid & needed_mask) != needed_mask || it.receiver_failsafe)
               vote_count++;
            else
               vote_count--;
            if (vote_count >= 2) begin
               vote_count = 0;
               lost_flag  = 1'b1;
               if (it.armed) begin
                  if (it.gps_enabled) res.home = 1'b1;
                  else res.land = 1'b1;
               end
            end else if (vote_count <= -2) begin
               vote_count = 0;
               if (lost_flag) begin
                  lost_flag = 1'b0;
                  if (it.in_takeoff) res.finish = 1'b1;
               end
            end
         end
      end
      res.valid_mask = chan_valid;
      res.link_lost  = lost_flag;
      return res;
   endfunction

   function automatic rcwd_pkg::item_type make_item(logic cmd,
                                                    logic [rcwd_pkg::CHAN_W-1:0] ch,
                                                    logic [rcwd_pkg::ELAPSED_W-1:0] el,
                                                    logic fs, logic arm, logic gps,
                                                    logic tko);
      rcwd_pkg::item_type it;
      it.command           = cmd;
      it.channel           = ch;
      it.elapsed_ms        = el;
      it.receiver_failsafe = fs;
      it.armed             = arm;
      it.gps_enabled       = gps;
      it.in_takeoff        = tko;
      return it;
   endfunction

   // Gap length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(3, 1);
      if (r < 95) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // Response side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_field(string name, logic [rcwd_pkg::MASK_W-1:0] want,
                               logic [rcwd_pkg::MASK_W-1:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      watchdog_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_land_request) land_seen++;
         if (rsp_home_request) home_seen++;
         if (rsp_takeoff_finish_request) finish_seen++;
         if (rsp_link_lost) lost_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual mask %0h", $time,
                     rsp_valid_mask);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("valid_mask", want.valid_mask, rsp_valid_mask);
            report_field("link_lost", rcwd_pkg::MASK_W'(want.link_lost),
                         rcwd_pkg::MASK_W'(rsp_link_lost));
            report_field("land_request", rcwd_pkg::MASK_W'(want.land),
                         rcwd_pkg::MASK_W'(rsp_land_request));
            report_field("home_request", rcwd_pkg::MASK_W'(want.home),
                         rcwd_pkg::MASK_W'(rsp_home_request));
            report_field("takeoff_finish_request", rcwd_pkg::MASK_W'(want.finish),
                         rcwd_pkg::MASK_W'(rsp_takeoff_finish_request));
         end
      end
   end

   // Present one item and hold it until accepted; valid stays high afterwards unless an idle stretch follows
   task automatic send_item(rcwd_pkg::item_type it);
      @(negedge clock);
      req_valid             <= 1'b1;
      req_command           <= it.command;
      req_channel           <= it.channel;
      req_elapsed_ms        <= it.elapsed_ms;
      req_receiver_failsafe <= it.receiver_failsafe;
      req_armed             <= it.armed;
      req_gps_enabled       <= it.gps_enabled;
      req_in_takeoff        <= it.in_takeoff;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(advance_watchdog(it));
      items_sent++;
      // optional idle stretch after the item
      if ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (pick_gap() - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every response has come back and the pipe is empty
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [rcwd_pkg::CSR_IDX_W-1:0] idx,
                            logic [rcwd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         rcwd_pkg::CSR_CHANNEL_TIMEOUT: timeout_ms  = data[rcwd_pkg::MS_W-1:0];
         rcwd_pkg::CSR_VOTE_PERIOD:     period_ms   = data[rcwd_pkg::MS_W-1:0];
         rcwd_pkg::CSR_REQUIRED_MASK:   needed_mask = data[rcwd_pkg::MASK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(int unsigned tmo, int unsigned per, int unsigned msk);
      wait_drained();
      write_reg(rcwd_pkg::CSR_CHANNEL_TIMEOUT, rcwd_pkg::CSR_DATA_W'(tmo));
      write_reg(rcwd_pkg::CSR_VOTE_PERIOD, rcwd_pkg::CSR_DATA_W'(per));
      write_reg(rcwd_pkg::CSR_REQUIRED_MASK, rcwd_pkg::CSR_DATA_W'(msk));
      settings_count++;
   endtask

   // Reset registers: feeds at channel extremes, clamping, ticks at elapsed extremes
   task automatic test_reset_defaults();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      settings_count++;
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'd7, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'hFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'd8, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0));
   endtask

   // Zero timeout and zero period: every channel drops, a vote on every tick
   task automatic test_zero_registers();
      apply_settings(0, 0, 8'hFF);
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'd3, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
   endtask

   // Vote outcomes: landing, return home, repeated loss, recovery with and without loss, loss while disarmed
   task automatic test_vote_outcomes();
      apply_settings(1000, 0, 8'h01);
      send_item(make_item(rcwd_pkg::CMD_FEED, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      repeat (2) send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0,
                                     1'b1, 1'b1, 1'b0, 1'b0));
      repeat (2) send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0,
                                     1'b1, 1'b1, 1'b1, 1'b0));
      repeat (2) send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0,
                                     1'b0, 1'b0, 1'b0, 1'b1));
      repeat (2) send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0,
                                     1'b0, 1'b0, 1'b0, 1'b1));
      repeat (2) send_item(make_item(rcwd_pkg::CMD_TICK, 8'd0, 8'd0,
                                     1'b1, 1'b0, 1'b1, 1'b0));
   endtask

   // Random traffic: feeds mostly from a drifting set of live channels, ticks of varied length
   task automatic random_traffic(int count);
      rcwd_pkg::item_type it;
      logic [7:0]         live_set;
      int                 r;
      live_set = 8'hFF;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) live_set = ($urandom_range(99) < 60) ? 8'hFF : 8'($urandom_range(255));
         it = make_item(rcwd_pkg::CMD_FEED, rcwd_pkg::CHAN_W'($urandom_range(255)),
                        rcwd_pkg::ELAPSED_W'($urandom_range(255)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
         if ($urandom_range(99) < 55) begin
            if ($urandom_range(9) != 0 && live_set != 0) begin
               do it.channel = rcwd_pkg::CHAN_W'($urandom_range(7));
               while (!live_set[it.channel]);
            end
         end else begin
            it.command = rcwd_pkg::CMD_TICK;
            r = $urandom_range(99);
            if (r < 40) it.elapsed_ms = rcwd_pkg::ELAPSED_W'($urandom_range(15));
            else if (r < 80) it.elapsed_ms = rcwd_pkg::ELAPSED_W'($urandom_range(80, 16));
            it.receiver_failsafe = ($urandom_range(99) < 15);
         end
         send_item(it);
      end
   endtask

   task automatic test_random_settings();
      int unsigned tmo_list [8] = '{1, 1000, 0, 500, 1000, 1, 0, 0};
      int unsigned per_list [8] = '{1, 1000, 0, 500, 1, 1000, 0, 0};
      int unsigned msk_list [8] = '{8'h00, 8'hFF, 8'h5A, 8'h0F, 8'hFF, 8'h80, 0, 0};
      for (int p = 0; p < 8; p++) begin
         // last two settings are fully random
         if (p >= 6) begin
            tmo_list[p] = $urandom_range(1000, 1);
            per_list[p] = $urandom_range(1000, 1);
            msk_list[p] = $urandom_range(255);
         end
         apply_settings(tmo_list[p], per_list[p], msk_list[p]);
         case ($urandom_range(2))
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 15; rsp_stall_pct = 15; end
            default: begin req_idle_pct = 40; rsp_stall_pct = 40; end
         endcase
         random_traffic(200);
      end
   endtask

   // Run-time limit
   initial begin
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // Test sequence
   initial begin
      clear_watchdog();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_registers();
      test_vote_outcomes();
      test_random_settings();
      wait_drained();
      $display("Covered %0d items under %0d register settings, %0d responses checked.",
               items_sent, settings_count, results_seen);
      $display("Seen: %0d landing, %0d return-home, %0d takeoff-finish pulses, %0d lost.",
               land_seen, home_seen, finish_seen, lost_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
